FILE: rtl/core/jks_pkg.sv
`default_nettype none
package jks_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS);

  localparam logic FUNC_JACOBI    = 1'b0;
  localparam logic FUNC_KRONECKER = 1'b1;

  localparam logic signed [1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [1:0] SYM_POS  = 2'sb01;
  localparam logic signed [1:0] SYM_NEG  = 2'sb11;

  localparam logic [2:0] MOD8_THREE = 3'd3;
  localparam logic [2:0] MOD8_FIVE  = 3'd5;

endpackage
`default_nettype wire

FILE: rtl/core/jks_divider.sv
`default_nettype none
module jks_divider (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [jks_pkg::WORD_BITS-1:0]  dividend,
  input  wire logic [jks_pkg::WORD_BITS-1:0]  divisor,
  output logic                                done,
  output logic [jks_pkg::WORD_BITS-1:0]       remainder
);

  logic                            busy_r;
  logic                            done_r;
  logic [jks_pkg::CNT_BITS-1:0]    cnt_r;
  logic [jks_pkg::WORD_BITS-1:0]   quo_r;
  logic [jks_pkg::WORD_BITS-1:0]   dvs_r;
  logic [jks_pkg::WORD_BITS-1:0]   rem_r;
  logic [jks_pkg::WORD_BITS:0]     partial;
  logic [jks_pkg::WORD_BITS:0]     diff;
  logic [jks_pkg::WORD_BITS-1:0]   rem_nxt;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    partial = {rem_r, quo_r[jks_pkg::WORD_BITS-1]};
    diff    = partial - {1'b0, dvs_r};
    if (partial >= {1'b0, dvs_r}) begin
      rem_nxt = diff[jks_pkg::WORD_BITS-1:0];
    end else begin
      rem_nxt = partial[jks_pkg::WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= jks_pkg::CNT_BITS'(jks_pkg::WORD_BITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[jks_pkg::WORD_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("remainder not below divisor");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/jacobi_kronecker_symbol.sv
`default_nettype none
// Flow: factors of two are stripped one at a time by the sequencer, and each remainder
// step runs on the bit-serial divider instance.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// The result register lets a new word start while the previous result waits.
module jacobi_kronecker_symbol (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_func,
  input  wire logic [jks_pkg::WORD_BITS-1:0]       in_top_value,
  input  wire logic [jks_pkg::WORD_BITS-1:0]       in_bottom_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [1:0]                        out_symbol,
  output logic [jks_pkg::WORD_BITS-1:0]            out_common_factor,
  output logic                                     out_not_coprime,
  output logic                                     out_bad_input
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KSTRIP,
    ST_LOOP,
    ST_STRIP,
    ST_DIV,
    ST_KMUL,
    ST_FIN
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            func_r, func_nxt;
  logic [jks_pkg::WORD_BITS-1:0]   dvs_r, dvs_nxt;
  logic [jks_pkg::WORD_BITS-1:0]   dvd_r, dvd_nxt;
  logic                            neg_r, neg_nxt;
  logic [jks_pkg::CNT_BITS-1:0]    k_r, k_nxt;
  logic [2:0]                      am8_r, am8_nxt;
  logic signed [1:0]               res_sym_r, res_sym_nxt;
  logic [jks_pkg::WORD_BITS-1:0]   res_fac_r, res_fac_nxt;
  logic                            res_nc_r, res_nc_nxt;
  logic                            res_bad_r, res_bad_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic signed [1:0]               out_sym_r, out_sym_nxt;
  logic [jks_pkg::WORD_BITS-1:0]   out_fac_r, out_fac_nxt;
  logic                            out_nc_r, out_nc_nxt;
  logic                            out_bad_r, out_bad_nxt;

  logic                            div_start;
  logic                            div_done;
  logic [jks_pkg::WORD_BITS-1:0]   div_rem;

  logic                            do_ok;
  logic                            do_fail;
  logic [2:0]                      dvd_m1;
  logic [2:0]                      dvd_p1;
  logic                            two_flip;
  logic [jks_pkg::WORD_BITS-1:0]   pow2;
  logic                            accept;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  // Low bits of (b-1)/2 and (b+1)/2 come from the low three bits of b.
  assign dvd_m1   = dvd_r[2:0] - 3'd1;
  assign dvd_p1   = dvd_r[2:0] + 3'd1;
  assign two_flip = dvd_p1[1] ? dvd_m1[2] : dvd_p1[2];
  assign pow2     = {{(jks_pkg::WORD_BITS-1){1'b0}}, 1'b1} << k_r;

  jks_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dvd_r),
    .divisor   (dvs_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    dvs_nxt     = dvs_r;
    dvd_nxt     = dvd_r;
    neg_nxt     = neg_r;
    k_nxt       = k_r;
    am8_nxt     = am8_r;
    res_sym_nxt = res_sym_r;
    res_fac_nxt = res_fac_r;
    res_nc_nxt  = res_nc_r;
    res_bad_nxt = res_bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sym_nxt = out_sym_r;
    out_fac_nxt = out_fac_r;
    out_nc_nxt  = out_nc_r;
    out_bad_nxt = out_bad_r;
    div_start   = 1'b0;
    do_ok       = 1'b0;
    do_fail     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt    = in_func;
          dvs_nxt     = in_top_value;
          dvd_nxt     = in_bottom_value;
          am8_nxt     = in_top_value[2:0];
          neg_nxt     = 1'b0;
          k_nxt       = '0;
          res_bad_nxt = 1'b0;
          if (in_func == jks_pkg::FUNC_JACOBI) begin
            state_nxt = ST_LOOP;
          end else if (in_bottom_value == '0) begin
            res_sym_nxt = jks_pkg::SYM_ZERO;
            res_fac_nxt = '0;
            res_nc_nxt  = 1'b0;
            res_bad_nxt = 1'b1;
            state_nxt   = ST_FIN;
          end else begin
            state_nxt = ST_KSTRIP;
          end
        end
      end
      ST_KSTRIP: begin
        if (!dvd_r[0]) begin
          dvd_nxt = dvd_r >> 1;
          if (am8_r == jks_pkg::MOD8_THREE || am8_r == jks_pkg::MOD8_FIVE) begin
            neg_nxt = !neg_r;
          end else if (!dvs_r[0]) begin
            dvs_nxt = dvs_r >> 1;
            k_nxt   = k_r + 1'b1;
          end
        end else if (dvd_r == jks_pkg::WORD_BITS'(1) || dvs_r == jks_pkg::WORD_BITS'(1)) begin
          do_ok = 1'b1;
        end else begin
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (dvs_r == '0) begin
          do_fail = 1'b1;
        end else if (dvs_r == jks_pkg::WORD_BITS'(1)) begin
          do_ok = 1'b1;
        end else begin
          state_nxt = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (!dvs_r[0]) begin
          dvs_nxt = dvs_r >> 1;
          neg_nxt = neg_r ^ two_flip;
        end else if (dvs_r == jks_pkg::WORD_BITS'(1)) begin
          do_ok = 1'b1;
        end else begin
          neg_nxt   = neg_r ^ (dvd_m1[1] & dvs_r[1]);
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          dvd_nxt   = dvs_r;
          dvs_nxt   = div_rem;
          state_nxt = ST_LOOP;
        end
      end
      ST_KMUL: begin
        if (k_r == '0) begin
          res_sym_nxt = jks_pkg::SYM_ZERO;
          res_fac_nxt = dvd_r;
          res_nc_nxt  = 1'b1;
          state_nxt   = ST_FIN;
        end else begin
          dvd_nxt = dvd_r << 1;
          k_nxt   = k_r - 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = res_sym_r;
          out_fac_nxt   = res_fac_r;
          out_nc_nxt    = res_nc_r;
          out_bad_nxt   = res_bad_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_ok) begin
      state_nxt = ST_FIN;
      if (k_r != '0) begin
        res_sym_nxt = jks_pkg::SYM_ZERO;
        res_fac_nxt = pow2;
        res_nc_nxt  = 1'b1;
      end else begin
        res_sym_nxt = neg_r ? jks_pkg::SYM_NEG : jks_pkg::SYM_POS;
        res_fac_nxt = '0;
        res_nc_nxt  = 1'b0;
      end
    end

    if (do_fail) begin
      if (func_r == jks_pkg::FUNC_KRONECKER) begin
        state_nxt = ST_KMUL;
      end else if (dvd_r == jks_pkg::WORD_BITS'(1)) begin
        state_nxt   = ST_FIN;
        res_sym_nxt = neg_r ? jks_pkg::SYM_NEG : jks_pkg::SYM_POS;
        res_fac_nxt = '0;
        res_nc_nxt  = 1'b0;
      end else begin
        state_nxt   = ST_FIN;
        res_sym_nxt = jks_pkg::SYM_ZERO;
        res_fac_nxt = dvd_r;
        res_nc_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r    <= func_nxt;
    dvs_r     <= dvs_nxt;
    dvd_r     <= dvd_nxt;
    neg_r     <= neg_nxt;
    k_r       <= k_nxt;
    am8_r     <= am8_nxt;
    res_sym_r <= res_sym_nxt;
    res_fac_r <= res_fac_nxt;
    res_nc_r  <= res_nc_nxt;
    res_bad_r <= res_bad_nxt;
    out_sym_r <= out_sym_nxt;
    out_fac_r <= out_fac_nxt;
    out_nc_r  <= out_nc_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_symbol        = out_sym_r;
  assign out_common_factor = out_fac_r;
  assign out_not_coprime   = out_nc_r;
  assign out_bad_input     = out_bad_r;

`ifndef NO_ASSERTIONS
  a_sym_zero_iff_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_sym_r == jks_pkg::SYM_ZERO) == (out_nc_r || out_bad_r)))
    else $error("symbol and flags disagree");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_nc_r && out_bad_r))
    else $error("not_coprime and bad_input both set");
  a_div_operand_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dvs_r[0] && dvs_r != jks_pkg::WORD_BITS'(1)))
    else $error("divisor not odd above one during remainder step");
`endif

endmodule
`default_nettype wire
